// ===== rtl/mslp_pkg.sv =====
// Shared types and codes for the multi-stack linked pool.
// Used by multi_stack_linked_pool_unit; no dependencies.
package mslp_pkg;

  // Request actions
  localparam logic [2:0] ACT_PUSH     = 3'd0;
  localparam logic [2:0] ACT_POP      = 3'd1;
  localparam logic [2:0] ACT_PEEK     = 3'd2;
  localparam logic [2:0] ACT_SIZE     = 3'd3;
  localparam logic [2:0] ACT_IS_EMPTY = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ID  = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // One result as delivered on the output channel
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [8:0]  depth;
    logic        empty;
  } res_t;

endpackage

// ===== rtl/mslp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mslp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/multi_stack_linked_pool_unit.sv =====
// Top level of the multi-stack linked pool: sequencer, stack pointers, counters.
// Depends on mslp_pkg and mslp_ram.
//
// Up to MAX_STACKS LIFO stacks share a pool of POOL_DEPTH linked nodes held in two
// RAMs (data words and links). A request is taken when in_valid_i is high and
// in_stall_o is low; one result follows each request, in order, through an output
// register. Size, is-empty, error results and pushes onto never-used nodes go from
// the execute state straight to the response state; pop, peek and pushes that reuse a
// freed node first pass through a read state for the registered read of the node
// RAMs before the stack top and free list are updated. A new request is not taken
// while an earlier result still waits on a stalled output. The node RAMs need no
// clearing after reset; the block is ready as soon as reset is released. Write the
// stack-count register over the cfg port only while the block is idle; the block itself does not enforce this.
module multi_stack_linked_pool_unit #(
  parameter int MAX_STACKS = 8,
  parameter int POOL_DEPTH = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [3:0]  stack_number_i,
  input  logic [31:0] data_in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] data_out_o,
  output logic [8:0]  depth_now_o,
  output logic        is_empty_o,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int VW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH_RD,
    S_POP_RD,
    S_PEEK_RD,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  // request registers
  logic [2:0]    act_q;
  logic [3:0]    id_q;
  logic [VW-1:0] word_q;

  // stack and pool state
  logic [3:0]    limit_q;
  logic [CW-1:0] cnt_q [MAX_STACKS];
  logic [AW-1:0] top_q [MAX_STACKS];
  logic [CW-1:0] fresh_q;
  logic [CW-1:0] free_cnt_q;
  logic [AW-1:0] free_head_q;

  // result registers
  mslp_pkg::res_t res_q, res_d, out_q;
  logic           res_ld;
  logic           out_valid_q;
  logic           out_ld;

  // RAM ports
  logic          val_we, val_re, lnk_we, lnk_re;
  logic [AW-1:0] val_waddr, val_raddr, lnk_waddr, lnk_raddr;
  logic [AW-1:0] lnk_wdata, lnk_rdata;
  logic [VW-1:0] val_rdata;

  // update strobes from the sequencer
  logic          cnt_inc, cnt_dec, fresh_inc, free_inc, free_dec;
  logic          top_we, fh_we;
  logic [AW-1:0] top_wdata, fh_wdata;

  // decode of the held request
  logic            id_ok;
  logic [SW-1:0]   sidx;
  logic [CW-1:0]   cnt_s;
  logic            cnt_zero;
  logic [CW+8:0]   depth_ext;
  logic            req_acc;

  assign req_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign id_ok     = ({1'b0, id_q} < {1'b0, limit_q}) && ({1'b0, id_q} < 5'(MAX_STACKS));
  assign sidx      = id_q[SW-1:0];
  assign cnt_s     = cnt_q[sidx];
  assign cnt_zero  = (cnt_s == '0);
  assign depth_ext = (CW + 9)'(cnt_s);

  // sequencer and RAM control
  always_comb begin
    state_d   = state_q;
    res_d     = '0;
    res_ld    = 1'b0;
    val_we    = 1'b0;
    val_re    = 1'b0;
    lnk_we    = 1'b0;
    lnk_re    = 1'b0;
    val_waddr = fresh_q[AW-1:0];
    lnk_waddr = fresh_q[AW-1:0];
    lnk_wdata = top_q[sidx];
    val_raddr = top_q[sidx];
    lnk_raddr = top_q[sidx];
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    fresh_inc = 1'b0;
    free_inc  = 1'b0;
    free_dec  = 1'b0;
    top_we    = 1'b0;
    top_wdata = fresh_q[AW-1:0];
    fh_we     = 1'b0;
    fh_wdata  = lnk_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_ld  = 1'b1;
        state_d = S_RESP;
        if (act_q <= mslp_pkg::ACT_IS_EMPTY && !id_ok) begin
          res_d.status = mslp_pkg::ST_BAD_ID;
          res_d.empty  = (act_q == mslp_pkg::ACT_IS_EMPTY);
        end else begin
          unique case (act_q)
            mslp_pkg::ACT_PUSH: begin
              if (free_cnt_q != '0) begin
                // reuse a freed node: fetch its link first
                lnk_re    = 1'b1;
                lnk_raddr = free_head_q;
                state_d   = S_PUSH_RD;
              end else if (fresh_q < CW'(POOL_DEPTH)) begin
                val_we    = 1'b1;
                lnk_we    = 1'b1;
                top_we    = 1'b1;
                cnt_inc   = 1'b1;
                fresh_inc = 1'b1;
              end else begin
                res_d.status = mslp_pkg::ST_FULL;
              end
            end
            mslp_pkg::ACT_POP: begin
              if (cnt_zero) begin
                res_d.status = mslp_pkg::ST_EMPTY;
              end else begin
                val_re  = 1'b1;
                lnk_re  = 1'b1;
                state_d = S_POP_RD;
              end
            end
            mslp_pkg::ACT_PEEK: begin
              if (cnt_zero) begin
                res_d.status = mslp_pkg::ST_EMPTY;
              end else begin
                val_re  = 1'b1;
                state_d = S_PEEK_RD;
              end
            end
            mslp_pkg::ACT_SIZE: begin
              res_d.depth = depth_ext[8:0];
            end
            mslp_pkg::ACT_IS_EMPTY: begin
              res_d.empty = cnt_zero;
            end
            default: begin
              // unused action codes: all-zero ok result
            end
          endcase
        end
      end
      S_PUSH_RD: begin
        // node = free_head, new free_head = its link
        val_we    = 1'b1;
        val_waddr = free_head_q;
        lnk_we    = 1'b1;
        lnk_waddr = free_head_q;
        top_we    = 1'b1;
        top_wdata = free_head_q;
        fh_we     = 1'b1;
        fh_wdata  = lnk_rdata;
        cnt_inc   = 1'b1;
        free_dec  = 1'b1;
        res_ld    = 1'b1;
        state_d   = S_RESP;
      end
      S_POP_RD: begin
        // unlink the top node and hand it to the free list
        lnk_we     = 1'b1;
        lnk_waddr  = top_q[sidx];
        lnk_wdata  = free_head_q;
        top_we     = 1'b1;
        top_wdata  = lnk_rdata;
        fh_we      = 1'b1;
        fh_wdata   = top_q[sidx];
        cnt_dec    = 1'b1;
        free_inc   = 1'b1;
        res_d.data = 32'(val_rdata);
        res_ld     = 1'b1;
        state_d    = S_RESP;
      end
      S_PEEK_RD: begin
        res_d.data = 32'(val_rdata);
        res_ld     = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (out_ld) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_ld = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  // state, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= 4'd8;
      fresh_q     <= '0;
      free_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (fresh_inc) begin
        fresh_q <= fresh_q + CW'(1);
      end
      if (free_inc) begin
        free_cnt_q <= free_cnt_q + CW'(1);
      end else if (free_dec) begin
        free_cnt_q <= free_cnt_q - CW'(1);
      end
      if (cnt_inc) begin
        cnt_q[sidx] <= cnt_s + CW'(1);
      end else if (cnt_dec) begin
        cnt_q[sidx] <= cnt_s - CW'(1);
      end
      out_valid_q <= out_ld || (out_valid_q && out_stall_i);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      act_q  <= action_i;
      id_q   <= stack_number_i;
      word_q <= data_in_i[VW-1:0];
    end
    if (top_we) begin
      top_q[sidx] <= top_wdata;
    end
    if (fh_we) begin
      free_head_q <= fh_wdata;
    end
    if (res_ld) begin
      res_q <= res_d;
    end
    if (out_ld) begin
      out_q <= res_q;
    end
  end

  // node data words
  mslp_ram #(
    .WIDTH (VW),
    .DEPTH (POOL_DEPTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (word_q),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  // node links
  mslp_ram #(
    .WIDTH (AW),
    .DEPTH (POOL_DEPTH)
  ) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .re_i    (lnk_re),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign data_out_o  = out_q.data;
  assign depth_now_o = out_q.depth;
  assign is_empty_o  = out_q.empty;

`ifndef SYNTHESIS
  // never-used pointer stays within the pool
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= CW'(POOL_DEPTH))
    else $error("fresh node pointer beyond pool");

  // free list can only hold nodes that were handed out
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= fresh_q)
    else $error("free count exceeds allocated nodes");

  // an accepted request always starts execution
  a_acc_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> state_q == S_EXEC)
    else $error("accepted request did not start");

  // a successful pop grows the free list by one
  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_RD |=> free_cnt_q == $past(free_cnt_q) + CW'(1))
    else $error("pop did not return node to free list");

  // a new result is loaded only from the response state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> state_q == S_RESP && !in_stall_o == 1'b0)
    else $error("result loaded outside response state");
`endif

endmodule
